/* sv/ais_pkg.sv */
// shared constants and types for the ascending integer sorter
package ais_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int VALUE_W   = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [CNT_W-1:0]          count_t;

    // broadcast control to every cell
    typedef struct packed {
        logic   insert;
        logic   shift;
        value_t key;
    } cell_ctl_t;

    // what one cell shows its neighbors
    typedef struct packed {
        logic   occ;
        logic   lt;
        value_t value;
    } cell_link_t;

endpackage

/* sv/ais_item_if.sv */
// input channel: one integer of a set per request
interface ais_item_if;
    import ais_pkg::*;

    logic   valid;
    logic   ready;
    value_t value;
    logic   is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

/* sv/ais_result_if.sv */
// output channel: one sorted integer per request
interface ais_result_if;
    import ais_pkg::*;

    logic   valid;
    logic   ready;
    value_t sorted_value;
    logic   end_of_set;
    logic   overflowed;

    modport source (output valid, output sorted_value, output end_of_set, output overflowed,
                    input ready);
    modport sink   (input valid, input sorted_value, input end_of_set, input overflowed,
                    output ready);
endinterface

/* sv/ais_cell.sv */
// one cell of the insertion chain: holds one value, shifts right on insert, left on drain
module ais_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  ais_pkg::cell_ctl_t ctl,
    input  ais_pkg::cell_link_t left,
    input  ais_pkg::cell_link_t right,
    output ais_pkg::cell_link_t self
);
    import ais_pkg::*;

    value_t val_reg;
    value_t val_next;
    logic   occ_reg;
    logic   occ_next;
    logic   lt;

    // key goes at or before this cell; strict compare keeps equal values in arrival order
    assign lt = !occ_reg || (ctl.key < val_reg);

    always_comb
    begin
        val_next = val_reg;
        occ_next = occ_reg;
        if (ctl.shift)
        begin
            val_next = right.value;
            occ_next = right.occ;
        end
        else if (ctl.insert && lt)
        begin
            if (left.lt)
            begin
                val_next = left.value;
                occ_next = left.occ;
            end
            else
            begin
                val_next = ctl.key;
                occ_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign self = '{occ: occ_reg, lt: lt, value: val_reg};

endmodule

/* sv/ascending_integer_sorter_unit.sv */
// top level: collect a set of signed integers and return it in ascending order
// fill: one request per cycle while not draining; each value is inserted in place in the cell chain
// drain: after the request marked last, the set leaves one result per cycle from cell zero while results.ready is high
// no input is taken while draining
// first result is valid the cycle after the last request is accepted
// reset (rst_n, async, active low) empties every cell and clears the count and overflow flag
module ascending_integer_sorter_unit (
    input  logic          clk,
    input  logic          rst_n,
    ais_item_if.sink      items,
    ais_result_if.source  results
);
    import ais_pkg::*;

    // cell links, index 0 is the smallest value and the head of the output
    cell_link_t link [MAX_ITEMS];
    cell_link_t left_in [MAX_ITEMS];
    cell_link_t right_in [MAX_ITEMS];
    cell_ctl_t  ctl;

    count_t count_reg;
    count_t count_next;
    logic   draining_reg;
    logic   draining_next;
    logic   ovf_reg;
    logic   ovf_next;

    logic   in_fire;
    logic   out_fire;
    logic   room;

    assign room     = (count_reg < count_t'(MAX_ITEMS));
    assign in_fire  = items.valid && items.ready;
    assign out_fire = results.valid && results.ready;

    // input side stalls only while a set is being returned
    assign items.ready = !draining_reg;

    // broadcast: insert when there is room, otherwise the item is dropped
    assign ctl.insert = in_fire && room;
    assign ctl.shift  = out_fire;
    assign ctl.key    = items.value;

    // neighbor wiring; chain ends see an empty cell, and the one left of the head never claims the key
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign left_in[gi] = '{occ: 1'b0, lt: 1'b0, value: '0};
            end
            else
            begin : g_mid
                assign left_in[gi] = link[gi-1];
            end

            if (gi == MAX_ITEMS - 1)
            begin : g_tail
                assign right_in[gi] = '{occ: 1'b0, lt: 1'b1, value: '0};
            end
            else
            begin : g_body
                assign right_in[gi] = link[gi+1];
            end

            ais_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .left  (left_in[gi]),
                .right (right_in[gi]),
                .self  (link[gi])
            );
        end
    endgenerate

    // count tracks stored values during fill and values still to leave during drain
    always_comb
    begin
        count_next    = count_reg;
        draining_next = draining_reg;
        ovf_next      = ovf_reg;
        if (in_fire)
        begin
            if (room)
            begin
                count_next = count_reg + count_t'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (items.is_last)
            begin
                draining_next = 1'b1;
            end
        end
        if (out_fire)
        begin
            count_next = count_reg - count_t'(1);
            if (count_reg == count_t'(1))
            begin
                // last result of the set leaves, block is empty again
                draining_next = 1'b0;
                ovf_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            draining_reg <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            draining_reg <= draining_next;
            ovf_reg      <= ovf_next;
        end
    end

    // cell zero is the output register
    assign results.valid        = draining_reg;
    assign results.sorted_value = link[0].value;
    assign results.end_of_set   = (count_reg == count_t'(1));
    assign results.overflowed   = ovf_reg;

endmodule
